FILE: sv/sfe_pkg.sv
// shared types and constants for the fixed-point softmax block
// no dependencies
`default_nettype none
package sfe_pkg;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [15:0] ExpOffsetQ16 = 16'd4266;

  typedef enum logic [2:0] {
    ST_LOAD, ST_EXP_RD, ST_EXP, ST_DIV_RD, ST_DIV, ST_EMIT
  } state_t;

  // one queue entry from the front part
  typedef struct packed {
    logic signed [15:0] logit;
    logic               last;
    logic               dropped;
  } item_t;
endpackage
`default_nettype wire

FILE: sv/softmax_fast_exp.sv
// top level of the streaming softmax with shift-based exponential
// depends on sfe_pkg, sfe_front, sfe_back, sfe_ram
//
// Usage: logits stream in on s_axis (tdata = logit, tlast marks vector end).
// Elements past MaxLength are dropped and flagged on every result of the run.
// Loading takes one element per cycle through a two-entry queue.
// After the tlast transaction leaves the queue, an exponential pass handles
// each stored element with one memory read, then a multiply and shift.
// Results are then computed one at a time: each takes a memory read, a pass
// of the bit-serial divider and a handoff on m_axis.
// While the back part works on a run, s_axis accepts transactions until the
// two-entry queue is full and then stalls until the last result of the run is taken.
// Synchronous reset clears run state and the queue; stores need no clearing.
// When m_axis stalls, the current result holds until taken.
`default_nettype none
module softmax_fast_exp
  import sfe_pkg::*;
#(
  parameter int MaxLength = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] logit
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] probability, [21:16] element_index,
                                      // [22] overflowed, [23] zero
  output logic        m_axis_tlast
);
  logic  q_valid, q_pop, over;
  item_t q_head;
  logic [15:0] prob;
  logic [5:0]  index;

  sfe_front #(.MaxLength(MaxLength)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_logit(s_axis_tdata), .in_last(s_axis_tlast),
    .q_valid, .q_pop, .q_head);

  sfe_back #(.MaxLength(MaxLength)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_head,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_prob(prob), .out_index(index), .out_last(m_axis_tlast), .out_over(over));

  assign m_axis_tdata = {1'b0, over, index, prob};
endmodule
`default_nettype wire

FILE: sv/sfe_ram.sv
// generic single-port-write, registered-read RAM
// no dependencies
`default_nettype none
module sfe_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(Depth)-1:0]  waddr,
  input  wire [Width-1:0]          wdata,
  input  wire [$clog2(Depth)-1:0]  raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/sfe_front.sv
// front part: accepts logits, checks capacity, pushes into a two-entry queue
// depends on sfe_pkg
`default_nettype none
module sfe_front
  import sfe_pkg::*;
#(
  parameter int MaxLength = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] in_logit,
  input  wire         in_last,
  output logic        q_valid,
  input  wire         q_pop,
  output item_t       q_head
);
  localparam int CntW = $clog2(MaxLength + 1);
  logic [CntW-1:0] count;
  item_t           entry [2];
  logic [1:0]      fill;
  logic            push;
  item_t           pushed;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_head   = entry[0];

  always_comb begin
    pushed.logit   = in_logit;
    pushed.last    = in_last;
    pushed.dropped = (count == CntW'(MaxLength));
  end

  // per-run capacity count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (in_last) count <= '0;
      else if (!pushed.dropped) count <= count + 1'b1;
    end
  end

  // two-entry queue, no push while full
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
    if (q_pop && q_valid) begin
      entry[0] <= (fill == 2'd2) ? entry[1] : pushed;
    end else if (push) begin
      if (fill == 2'd0) entry[0] <= pushed;
      else entry[1] <= pushed;
    end
  end
endmodule
`default_nettype wire

FILE: sv/sfe_back.sv
// back part: stores logits, computes exponentials, sum and quotients
// depends on sfe_pkg and sfe_ram
`default_nettype none
module sfe_back
  import sfe_pkg::*;
#(
  parameter int MaxLength = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         q_valid,
  output logic        q_pop,
  input  item_t       q_head,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [15:0] out_prob,
  output logic [5:0]  out_index,
  output logic        out_last,
  output logic        out_over
);
  localparam int AW   = (MaxLength > 1) ? $clog2(MaxLength) : 1;
  localparam int CntW = $clog2(MaxLength + 1);

  state_t               state, state_next;
  logic signed [15:0]   run_max;
  logic [CntW-1:0]      count;
  logic [CntW-1:0]      idx;
  logic [22:0]          sum;
  logic                 dropped;
  logic [15:0]          lg_rd;
  logic [16:0]          ex_rd;
  logic                 lg_we, ex_we;
  logic [AW-1:0]        lg_ra, ex_ra, ex_wa;
  logic [16:0]          ex_val;
  logic [15:0]          n_val;
  logic [32:0]          t_prod;
  logic [24:0]          m_val;
  logic [8:0]           k_val;
  logic [15:0]          r_val;
  logic [9:0]           shift;
  logic [16:0]          mant;
  // restoring divider
  logic [39:0]          rem;
  logic [32:0]          quo;
  logic [5:0]           dstep;

  sfe_ram #(.Width(16), .Depth(1 << AW)) u_lg (
    .clk, .we(lg_we), .waddr(count[AW-1:0]), .wdata(q_head.logit),
    .raddr(lg_ra), .rdata(lg_rd));
  sfe_ram #(.Width(17), .Depth(1 << AW)) u_ex (
    .clk, .we(ex_we), .waddr(ex_wa), .wdata(ex_val),
    .raddr(ex_ra), .rdata(ex_rd));

  assign lg_ra = idx[AW-1:0];
  assign ex_ra = idx[AW-1:0];
  assign ex_wa = idx[AW-1:0];

  // approximate exponential of the read logit
  always_comb begin
    n_val  = 16'(run_max - $signed(lg_rd));
    t_prod = 33'(n_val) * 33'(Log2eQ16);
    m_val  = 25'((t_prod + 33'd128) >> 8) + 25'(ExpOffsetQ16);
    k_val  = m_val[24:16];
    r_val  = m_val[15:0];
    if (r_val == 16'd0) begin
      shift = {1'b0, k_val};
      mant  = 17'd65536;
    end else begin
      shift = {1'b0, k_val} + 10'd1;
      mant  = 17'(18'd131072 - 18'(r_val));
    end
    ex_val = (shift >= 10'd17) ? 17'd0 : (mant >> shift[4:0]);
  end

  assign lg_we = (state == ST_LOAD) && q_valid && !q_head.dropped;
  assign ex_we = (state == ST_EXP);
  assign q_pop = (state == ST_LOAD) && q_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   if (q_valid && q_head.last) begin
        state_next = (count == '0 && !lg_we) ? ST_LOAD : ST_EXP_RD;
      end
      ST_EXP_RD: state_next = ST_EXP;
      ST_EXP:    state_next = (idx + 1'b1 == count) ? ST_DIV_RD : ST_EXP_RD;
      ST_DIV_RD: state_next = ST_DIV;
      ST_DIV:    if (dstep == 6'd34) state_next = ST_EMIT;
      ST_EMIT:   if (out_ready) begin
        state_next = (idx + 1'b1 == count) ? ST_LOAD : ST_DIV_RD;
      end
      default:   state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_max <= -16'sd32768;
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
      idx     <= '0;
      dstep   <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (q_valid) begin
            if (q_head.dropped) dropped <= 1'b1;
            else begin
              count <= count + 1'b1;
              if (q_head.logit > run_max) run_max <= q_head.logit;
            end
            idx <= '0;
            sum <= '0;
            if (q_head.last && count == '0 && !lg_we) begin
              run_max <= -16'sd32768;
              dropped <= 1'b0;
            end
          end
        end
        ST_EXP: begin
          sum <= sum + 23'(ex_val);
          idx <= (idx + 1'b1 == count) ? '0 : idx + 1'b1;
        end
        ST_DIV_RD: dstep <= '0;
        ST_DIV: begin
          if (dstep == 6'd0) begin
            rem <= '0;
            quo <= {ex_rd, 16'd0};
            dstep <= 6'd1;
          end else if (dstep != 6'd34) begin
            if ({rem[38:0], quo[32]} >= {17'd0, sum}) begin
              rem <= {rem[38:0], quo[32]} - {17'd0, sum};
              quo <= {quo[31:0], 1'b1};
            end else begin
              rem <= {rem[38:0], quo[32]};
              quo <= {quo[31:0], 1'b0};
            end
            dstep <= dstep + 1'b1;
          end
        end
        ST_EMIT: if (out_ready) begin
          if (idx + 1'b1 == count) begin
            idx     <= '0;
            count   <= '0;
            sum     <= '0;
            dropped <= 1'b0;
            run_max <= -16'sd32768;
          end else idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == ST_EMIT);
  assign out_prob  = (sum == '0) ? 16'd0 : ((quo > 33'd65535) ? 16'hFFFF : quo[15:0]);
  assign out_index = 6'(idx);
  assign out_last  = (idx + 1'b1 == count);
  assign out_over  = dropped;
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// testbench for softmax_fast_exp: streams logit vectors, predicts every probability
// depends on sfe_pkg and softmax_fast_exp
`default_nettype none
module tb_top;
  import sfe_pkg::*;

  localparam int MaxLen = 64;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [15:0] probability;
    logic [5:0]  element_index;
    logic        last_probability;
    logic        overflowed;
  } prob_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] logit
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [15:0] probability, [21:16] element_index, [22] overflowed
  logic        m_axis_tlast;

  softmax_fast_exp dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // predictor state
  logic signed [15:0] vec_logits [MaxLen];
  logic [16:0]        vec_exps [MaxLen];
  logic signed [15:0] vec_max;
  int                 vec_count;
  logic               vec_dropped;
  prob_t              expected_probs [$];

  int  errors;
  int  idle_cycles;
  bit  hold_off;
  bit  gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shift-based exponential of max - logit
  function automatic logic [16:0] approx_exp(input logic [15:0] n);
    logic [40:0] t;
    logic [40:0] m;
    logic [24:0] k;
    logic [15:0] r;
    logic [24:0] sh;
    logic [17:0] mant;
    t = n * 41'd94548;
    m = ((t + 41'd128) >> 8) + 41'd4266;
    k = m[40:16];
    r = m[15:0];
    if (r == 16'd0) begin
      sh = k;
      mant = 18'd65536;
    end else begin
      sh = k + 25'd1;
      mant = 18'd131072 - r;
    end
    if (sh >= 25'd17) return 17'd0;
    return 17'(mant >> sh);
  endfunction

  // fold one logit into the vector, produce probabilities on the last one
  task automatic predict_logit(input logic [15:0] x, input logic last);
    logic [22:0] total;
    logic [47:0] q;
    prob_t       p;
    if (vec_count < MaxLen) begin
      vec_logits[vec_count] = x;
      if ($signed(x) > vec_max) vec_max = x;
      vec_count++;
    end else begin
      vec_dropped = 1'b1;
    end
    if (!last) return;
    total = '0;
    for (int i = 0; i < vec_count; i++) begin
      vec_exps[i] = approx_exp(16'(vec_max - vec_logits[i]));
      total = total + vec_exps[i];
    end
    for (int i = 0; i < vec_count; i++) begin
      q = (total == 0) ? 48'd0 : ({31'd0, vec_exps[i]} << 16) / total;
      p.probability = (q > 48'd65535) ? 16'hFFFF : q[15:0];
      p.element_index = 6'(i);
      p.last_probability = (i + 1 == vec_count);
      p.overflowed = vec_dropped;
      expected_probs.insert(expected_probs.size(), p);
    end
    vec_max = 16'sh8000;
    vec_count = 0;
    vec_dropped = 1'b0;
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one logit, with random bursts and gaps when gaps_on is set
  task automatic send_logit(input logic [15:0] x, input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_logit(x, last);
  endtask

  // receiver stall pattern and long hold-off
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (!gaps_on) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      prob_t exp_p;
      if (expected_probs.size() == 0) begin
        report("unexpected result", int'(m_axis_tdata), 0);
      end else begin
        exp_p = expected_probs.pop_front();
        if (m_axis_tdata[15:0] != exp_p.probability)
          report("probability", int'(m_axis_tdata[15:0]), int'(exp_p.probability));
        if (m_axis_tdata[21:16] != exp_p.element_index)
          report("element_index", int'(m_axis_tdata[21:16]), int'(exp_p.element_index));
        if (m_axis_tlast != exp_p.last_probability)
          report("last", int'(m_axis_tlast), int'(exp_p.last_probability));
        if (m_axis_tdata[22] != exp_p.overflowed)
          report("overflowed", int'(m_axis_tdata[22]), int'(exp_p.overflowed));
        if (m_axis_tdata[23] != 1'b0)
          report("pad bit", int'(m_axis_tdata[23]), 0);
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (!hold_off) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_vector(input int len);
    for (int i = 0; i < len; i++)
      send_logit(16'($urandom_range(0, 65535)), i == len - 1);
  endtask

  // extremes, single element, ties
  task automatic test_directed();
    send_logit(16'h7FFF, 1'b1);
    send_logit(16'h8000, 1'b1);
    send_logit(16'h7FFF, 1'b0);
    send_logit(16'h8000, 1'b0);
    send_logit(16'h0000, 1'b1);
    send_logit(16'h0100, 1'b0);
    send_logit(16'h0100, 1'b0);
    send_logit(16'h0000, 1'b0);
    send_logit(16'hFF00, 1'b0);
    send_logit(16'hFFFF, 1'b0);
    send_logit(16'h5555, 1'b0);
    send_logit(16'hAAAA, 1'b1);
    send_logit(16'h0000, 1'b0);
    send_logit(16'h0001, 1'b1);
  endtask

  // overflow: a full vector plus dropped items, the last one dropped too
  task automatic test_capacity();
    for (int i = 0; i < MaxLen + 2; i++)
      send_logit(16'($urandom_range(0, 2047)), i == MaxLen + 1);
  endtask

  // random short vectors, mixing full-range and near-range logits
  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    while (sent < 32) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 1))
          send_logit(16'($urandom_range(0, 65535)), i == len - 1);
        else
          send_logit(16'($signed(16'($urandom_range(0, 2047))) - 16'sd1024), i == len - 1);
      end
      sent += len;
    end
  endtask

  // receiver held off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_vector(3);
        send_vector(4);
        send_vector(2);
      end
    join
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_probs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    hold_off = 1'b0;
    gaps_on = 1'b0;
    vec_max = 16'sh8000;
    vec_count = 0;
    vec_dropped = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    gaps_on = 1'b1;
    test_capacity();
    test_random();
    drain();
    test_backpressure();
    gaps_on = 1'b0;
    send_vector(5);
    drain();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
